@@ rtl/qpr_pkg.sv @@
// Shared constants and width helpers for the quaternion point rotator.
// Used by the front end, back end and top level; depends on nothing else.
package qpr_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 14;

  localparam int QUAT_W  = 16;  // quaternion component width
  localparam int POINT_W = 32;  // point and result component width
  localparam int SQ_W    = 31;  // square of one quaternion component
  localparam int MAG_W   = 33;  // sum of four squares
  localparam int PROD_W  = 48;  // quaternion times point component
  localparam int TSUM_W  = 50;  // sum of three such products, with rounding headroom

  // Fraction bits of the unit conjugate.
  function automatic int unit_frac_bits(input int qf);
    unit_frac_bits = (qf + 10 < 30) ? qf + 10 : 30;
  endfunction

  // Width of one rounded component of q * (0,p).
  function automatic int t_width(input int qf);
    t_width = TSUM_W + 1 - qf;
  endfunction

endpackage

@@ rtl/qpr_queue.sv @@
// Two-entry queue that parts the front end from the back end.
// Depends on nothing but its width parameter.
module qpr_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_take,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] slot [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         wr;
  logic         rd;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = slot[rp];
  assign wr       = wr_valid && wr_ready;
  assign rd       = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      case ({wr, rd})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wp] <= wr_data;
    end
  end

  a_take_only_when_valid: assert property (@(posedge clk) disable iff (rst)
    rd_take |-> rd_valid)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> cnt == $past(cnt) + 2'd1)
    else $error("queue count did not follow a lone write");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (rd && !wr) |=> cnt == $past(cnt) - 2'd1)
    else $error("queue count did not follow a lone read");

  a_pointers: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> wp == rp)
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/qpr_front.sv @@
// Front end: accepts transactions, forms the squared magnitude and q * (0,p).
// Depends on qpr_pkg.
module qpr_front #(
  parameter int QUAT_FRAC_BITS = qpr_pkg::QUAT_FRAC_BITS_DEF,
  localparam int TW = qpr_pkg::t_width(QUAT_FRAC_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_w,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_x,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_y,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_z,
  input  logic signed [qpr_pkg::POINT_W-1:0] point_x,
  input  logic signed [qpr_pkg::POINT_W-1:0] point_y,
  input  logic signed [qpr_pkg::POINT_W-1:0] point_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [qpr_pkg::MAG_W-1:0]          mag,
  output logic [qpr_pkg::SQ_W-1:0]           csq_w,
  output logic [qpr_pkg::SQ_W-1:0]           csq_x,
  output logic [qpr_pkg::SQ_W-1:0]           csq_y,
  output logic [qpr_pkg::SQ_W-1:0]           csq_z,
  output logic [3:0]                         neg,
  output logic signed [TW-1:0]               t_w,
  output logic signed [TW-1:0]               t_x,
  output logic signed [TW-1:0]               t_y,
  output logic signed [TW-1:0]               t_z
);

  localparam int PW = qpr_pkg::PROD_W;
  localparam int SW = qpr_pkg::TSUM_W;
  localparam logic signed [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (QUAT_FRAC_BITS - 1);

  logic v1;
  logic adv1;
  logic adv2;

  logic signed [31:0] sq_full [4];
  logic signed [PW-1:0] pr [12];

  logic [qpr_pkg::SQ_W-1:0] sq1 [4];
  logic signed [PW-1:0]     pr1 [12];
  logic [3:0]               neg1;

  logic signed [SW-1:0] sum_w;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [SW-1:0] sum_z;
  logic signed [SW-1:0] sh_w;
  logic signed [SW-1:0] sh_x;
  logic signed [SW-1:0] sh_y;
  logic signed [SW-1:0] sh_z;

  assign adv2 = !out_valid || out_ready;
  assign adv1 = !v1 || adv2;
  assign full = !adv1;

  assign sq_full[0] = rot_w * rot_w;
  assign sq_full[1] = rot_x * rot_x;
  assign sq_full[2] = rot_y * rot_y;
  assign sq_full[3] = rot_z * rot_z;

  assign pr[0]  = rot_x * point_x;
  assign pr[1]  = rot_y * point_y;
  assign pr[2]  = rot_z * point_z;
  assign pr[3]  = rot_w * point_x;
  assign pr[4]  = rot_y * point_z;
  assign pr[5]  = rot_z * point_y;
  assign pr[6]  = rot_w * point_y;
  assign pr[7]  = rot_z * point_x;
  assign pr[8]  = rot_x * point_z;
  assign pr[9]  = rot_w * point_z;
  assign pr[10] = rot_x * point_y;
  assign pr[11] = rot_y * point_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= push;
      end
      if (adv2) begin
        out_valid <= v1;
      end
    end
  end

  // Stage one: squares, partial products and the signs of the conjugate.
  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 4; i++) begin
        sq1[i] <= sq_full[i][qpr_pkg::SQ_W-1:0];
      end
      for (int i = 0; i < 12; i++) begin
        pr1[i] <= pr[i];
      end
      neg1[0] <= rot_w[qpr_pkg::QUAT_W-1];
      neg1[1] <= (rot_x > 0);
      neg1[2] <= (rot_y > 0);
      neg1[3] <= (rot_z > 0);
    end
  end

  always_comb begin
    sum_w = -SW'(pr1[0]) - SW'(pr1[1]) - SW'(pr1[2]);
    sum_x = SW'(pr1[3]) + SW'(pr1[4]) - SW'(pr1[5]);
    sum_y = SW'(pr1[6]) + SW'(pr1[7]) - SW'(pr1[8]);
    sum_z = SW'(pr1[9]) + SW'(pr1[10]) - SW'(pr1[11]);
    sh_w  = (sum_w + RND) >>> QUAT_FRAC_BITS;
    sh_x  = (sum_x + RND) >>> QUAT_FRAC_BITS;
    sh_y  = (sum_y + RND) >>> QUAT_FRAC_BITS;
    sh_z  = (sum_z + RND) >>> QUAT_FRAC_BITS;
  end

  // Stage two: magnitude and the rounded components of q * (0,p).
  always_ff @(posedge clk) begin
    if (adv2) begin
      mag   <= {2'b00, sq1[0]} + {2'b00, sq1[1]} + {2'b00, sq1[2]} + {2'b00, sq1[3]};
      csq_w <= sq1[0];
      csq_x <= sq1[1];
      csq_y <= sq1[2];
      csq_z <= sq1[3];
      neg   <= neg1;
      t_w   <= sh_w[TW-1:0];
      t_x   <= sh_x[TW-1:0];
      t_y   <= sh_y[TW-1:0];
      t_z   <= sh_z[TW-1:0];
    end
  end

endmodule

@@ rtl/qpr_back.sv @@
// Back end: pipelined bit-by-bit search for the unit conjugate, then t * u and saturation.
// Depends on qpr_pkg.
module qpr_back #(
  parameter int QUAT_FRAC_BITS = qpr_pkg::QUAT_FRAC_BITS_DEF,
  localparam int TW = qpr_pkg::t_width(QUAT_FRAC_BITS)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_take,
  input  logic [qpr_pkg::MAG_W-1:0]          mag,
  input  logic [qpr_pkg::SQ_W-1:0]           csq_w,
  input  logic [qpr_pkg::SQ_W-1:0]           csq_x,
  input  logic [qpr_pkg::SQ_W-1:0]           csq_y,
  input  logic [qpr_pkg::SQ_W-1:0]           csq_z,
  input  logic [3:0]                         neg,
  input  logic signed [TW-1:0]               t_w,
  input  logic signed [TW-1:0]               t_x,
  input  logic signed [TW-1:0]               t_y,
  input  logic signed [TW-1:0]               t_z,
  input  logic                               pop,
  output logic                               empty,
  output logic signed [qpr_pkg::POINT_W-1:0] rotated_x,
  output logic signed [qpr_pkg::POINT_W-1:0] rotated_y,
  output logic signed [qpr_pkg::POINT_W-1:0] rotated_z,
  output logic                               clipped
);

  localparam int UF = qpr_pkg::unit_frac_bits(QUAT_FRAC_BITS);
  localparam int NS = UF + 1;                       // one stage per root bit
  localparam int MW = qpr_pkg::MAG_W;
  localparam int CW = qpr_pkg::SQ_W;
  localparam int AW = 2 * UF + MW + 2;              // holds n^2 * m for any trial n
  localparam int BW = UF + MW + 1;                  // holds n * m
  localparam int PW = TW + UF + 2;
  localparam int RW = PW + 3;
  localparam int OW = qpr_pkg::POINT_W;
  localparam logic [UF:0] ONE_N = {{UF{1'b0}}, 1'b1};
  localparam logic signed [RW-1:0] RND = {{(RW-1){1'b0}}, 1'b1} << (UF - 1);
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = {{(RW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  logic en;
  logic o_valid;

  logic                  vs   [NS];
  logic [MW-1:0]         ms   [NS];
  logic [CW-1:0]         cs   [NS][4];
  logic [3:0]            ngs  [NS];
  logic signed [TW-1:0]  ts   [NS][4];
  logic [AW-1:0]         acc  [NS][4];
  logic [BW-1:0]         lin  [NS][4];
  logic [UF:0]           root [NS][4];

  // The whole back end moves together; it holds only while a result waits.
  assign en      = !o_valid || pop;
  assign in_take = en && in_valid;
  assign empty   = !o_valid;

  // Each stage settles one bit of n = floor(|c| * 2^UF / sqrt(m)), the largest n with
  // n^2 * m <= c^2 * 2^(2*UF). n^2 * m and n * m are kept so each trial is adds only.
  for (genvar s = 0; s < NS; s++) begin : g_srch
    localparam int BIT = UF - s;

    logic                 v_in;
    logic [MW-1:0]        m_in;
    logic [CW-1:0]        c_in [4];
    logic [3:0]           ng_in;
    logic signed [TW-1:0] t_in [4];
    logic [AW-1:0]        a_in [4];
    logic [BW-1:0]        b_in [4];
    logic [UF:0]          n_in [4];
    logic [AW-1:0]        trial [4];
    logic                 fit [4];

    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign m_in  = mag;
      assign c_in  = '{csq_w, csq_x, csq_y, csq_z};
      assign ng_in = neg;
      assign t_in  = '{t_w, t_x, t_y, t_z};
      assign a_in  = '{default: '0};
      assign b_in  = '{default: '0};
      assign n_in  = '{default: '0};
    end else begin : g_next
      assign v_in  = vs[s-1];
      assign m_in  = ms[s-1];
      assign c_in  = cs[s-1];
      assign ng_in = ngs[s-1];
      assign t_in  = ts[s-1];
      assign a_in  = acc[s-1];
      assign b_in  = lin[s-1];
      assign n_in  = root[s-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        trial[l] = a_in[l] + (AW'(b_in[l]) << (BIT + 1)) + (AW'(m_in) << (2 * BIT));
        fit[l]   = trial[l] <= (AW'(c_in[l]) << (2 * UF));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[s] <= 1'b0;
      end else if (en) begin
        vs[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ms[s]  <= m_in;
        cs[s]  <= c_in;
        ngs[s] <= ng_in;
        ts[s]  <= t_in;
        for (int l = 0; l < 4; l++) begin
          if (fit[l]) begin
            acc[s][l]  <= trial[l];
            lin[s][l]  <= b_in[l] + (BW'(m_in) << BIT);
            root[s][l] <= n_in[l] | (ONE_N << BIT);
          end else begin
            acc[s][l]  <= a_in[l];
            lin[s][l]  <= b_in[l];
            root[s][l] <= n_in[l];
          end
        end
      end
    end
  end

  logic signed [UF+1:0] u [4];
  logic signed [PW-1:0] pr [12];
  logic signed [PW-1:0] pp [12];
  logic                 vp;

  // A zero quaternion leaves the conjugate unscaled, which is zero.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (ms[NS-1] == '0) begin
        u[l] = '0;
      end else if (ngs[NS-1][l]) begin
        u[l] = -$signed({1'b0, root[NS-1][l]});
      end else begin
        u[l] = $signed({1'b0, root[NS-1][l]});
      end
    end
  end

  assign pr[0]  = ts[NS-1][1] * u[0];
  assign pr[1]  = ts[NS-1][0] * u[1];
  assign pr[2]  = ts[NS-1][2] * u[3];
  assign pr[3]  = ts[NS-1][3] * u[2];
  assign pr[4]  = ts[NS-1][2] * u[0];
  assign pr[5]  = ts[NS-1][0] * u[2];
  assign pr[6]  = ts[NS-1][3] * u[1];
  assign pr[7]  = ts[NS-1][1] * u[3];
  assign pr[8]  = ts[NS-1][3] * u[0];
  assign pr[9]  = ts[NS-1][0] * u[3];
  assign pr[10] = ts[NS-1][1] * u[2];
  assign pr[11] = ts[NS-1][2] * u[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vp      <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      vp      <= vs[NS-1];
      o_valid <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp <= pr;
    end
  end

  logic signed [RW-1:0] rsum [3];
  logic signed [RW-1:0] rsh  [3];
  logic [OW-1:0]        rsat [3];
  logic [2:0]           rclip;

  always_comb begin
    rsum[0] = RW'(pp[0]) + RW'(pp[1]) + RW'(pp[2]) - RW'(pp[3]);
    rsum[1] = RW'(pp[4]) + RW'(pp[5]) + RW'(pp[6]) - RW'(pp[7]);
    rsum[2] = RW'(pp[8]) + RW'(pp[9]) + RW'(pp[10]) - RW'(pp[11]);
    for (int k = 0; k < 3; k++) begin
      rsh[k] = (rsum[k] + RND) >>> UF;
      if (rsh[k] > SAT_HI) begin
        rsat[k]  = SAT_HI[OW-1:0];
        rclip[k] = 1'b1;
      end else if (rsh[k] < SAT_LO) begin
        rsat[k]  = SAT_LO[OW-1:0];
        rclip[k] = 1'b1;
      end else begin
        rsat[k]  = rsh[k][OW-1:0];
        rclip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rotated_x <= rsat[0];
      rotated_y <= rsat[1];
      rotated_z <= rsat[2];
      clipped   <= |rclip;
    end
  end

  a_root_bounded: assert property (@(posedge clk) disable iff (rst)
    (vs[NS-1] && ms[NS-1] != '0) |-> root[NS-1][0] <= (ONE_N << UF))
    else $error("unit conjugate exceeds one");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (!en && vs[NS-1]) |=> vs[NS-1] && $stable(root[NS-1][1]))
    else $error("search pipeline moved during a stall");

  a_result_follows_products: assert property (@(posedge clk) disable iff (rst)
    (en && vp) |=> o_valid)
    else $error("product stage transaction lost");

endmodule

@@ rtl/quaternion_point_rotate.sv @@
// Quaternion point rotator: p' = q * (0,p) * conj(q)/|q| in fixed point.
// Top level; depends on qpr_pkg, qpr_front, qpr_queue and qpr_back.
//
// Input channel: a transaction is taken at a clock edge with push high and
// full low; it carries the quaternion (Q1.14 by default) and a Q16.16 point.
// Result channel: while empty is low, the oldest result sits on rotated_x/y/z
// and clipped; it is taken at an edge with pop high. clipped is set when any
// component saturated to the 32-bit range.
// Throughput is one transaction per cycle while full stays low. The back end
// spends one pipeline stage per bit of the unit conjugate's root search, where
// UF = min(QUAT_FRAC_BITS + 10, 30) is the number of fraction bits of that
// unit conjugate.
// The front end and back end meet in a two-entry queue. When pop stays low with
// a result waiting, the back end holds, the queue fills and then full rises; no
// transaction is dropped. Synchronous reset empties every stage and the queue;
// no clearing pass is needed.
module quaternion_point_rotate #(
  parameter int QUAT_FRAC_BITS = qpr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_w,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_x,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_y,
  input  logic signed [qpr_pkg::QUAT_W-1:0]  rot_z,
  input  logic signed [qpr_pkg::POINT_W-1:0] point_x,
  input  logic signed [qpr_pkg::POINT_W-1:0] point_y,
  input  logic signed [qpr_pkg::POINT_W-1:0] point_z,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [qpr_pkg::POINT_W-1:0] rotated_x,
  output logic signed [qpr_pkg::POINT_W-1:0] rotated_y,
  output logic signed [qpr_pkg::POINT_W-1:0] rotated_z,
  output logic                               clipped
);

  localparam int TW = qpr_pkg::t_width(QUAT_FRAC_BITS);
  localparam int QW = qpr_pkg::MAG_W + 4 * qpr_pkg::SQ_W + 4 + 4 * TW;

  logic                      f_valid;
  logic                      f_ready;
  logic [qpr_pkg::MAG_W-1:0] f_mag;
  logic [qpr_pkg::SQ_W-1:0]  f_csq_w;
  logic [qpr_pkg::SQ_W-1:0]  f_csq_x;
  logic [qpr_pkg::SQ_W-1:0]  f_csq_y;
  logic [qpr_pkg::SQ_W-1:0]  f_csq_z;
  logic [3:0]                f_neg;
  logic signed [TW-1:0]      f_t_w;
  logic signed [TW-1:0]      f_t_x;
  logic signed [TW-1:0]      f_t_y;
  logic signed [TW-1:0]      f_t_z;

  logic                      b_valid;
  logic                      b_take;
  logic [qpr_pkg::MAG_W-1:0] b_mag;
  logic [qpr_pkg::SQ_W-1:0]  b_csq_w;
  logic [qpr_pkg::SQ_W-1:0]  b_csq_x;
  logic [qpr_pkg::SQ_W-1:0]  b_csq_y;
  logic [qpr_pkg::SQ_W-1:0]  b_csq_z;
  logic [3:0]                b_neg;
  logic signed [TW-1:0]      b_t_w;
  logic signed [TW-1:0]      b_t_x;
  logic signed [TW-1:0]      b_t_y;
  logic signed [TW-1:0]      b_t_z;

  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  qpr_front #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rot_w     (rot_w),
    .rot_x     (rot_x),
    .rot_y     (rot_y),
    .rot_z     (rot_z),
    .point_x   (point_x),
    .point_y   (point_y),
    .point_z   (point_z),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .mag       (f_mag),
    .csq_w     (f_csq_w),
    .csq_x     (f_csq_x),
    .csq_y     (f_csq_y),
    .csq_z     (f_csq_z),
    .neg       (f_neg),
    .t_w       (f_t_w),
    .t_x       (f_t_x),
    .t_y       (f_t_y),
    .t_z       (f_t_z)
  );

  assign q_wdata = {f_mag, f_csq_w, f_csq_x, f_csq_y, f_csq_z, f_neg,
                    f_t_w, f_t_x, f_t_y, f_t_z};

  qpr_queue #(
    .W(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_wdata),
    .rd_valid (b_valid),
    .rd_take  (b_take),
    .rd_data  (q_rdata)
  );

  assign {b_mag, b_csq_w, b_csq_x, b_csq_y, b_csq_z, b_neg,
          b_t_w, b_t_x, b_t_y, b_t_z} = q_rdata;

  qpr_back #(
    .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_valid),
    .in_take   (b_take),
    .mag       (b_mag),
    .csq_w     (b_csq_w),
    .csq_x     (b_csq_x),
    .csq_y     (b_csq_y),
    .csq_z     (b_csq_z),
    .neg       (b_neg),
    .t_w       (b_t_w),
    .t_x       (b_t_x),
    .t_y       (b_t_y),
    .t_z       (b_t_z),
    .pop       (pop),
    .empty     (empty),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .rotated_z (rotated_z),
    .clipped   (clipped)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for quaternion_point_rotate.
// Depends on qpr_pkg and the quaternion_point_rotate RTL; predicts each rotation in place.
`timescale 1ns / 100ps

module testbench;

  localparam int QF = qpr_pkg::QUAT_FRAC_BITS_DEF;
  localparam int UF = (QF + 10 < 30) ? QF + 10 : 30;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [qpr_pkg::QUAT_W-1:0]  qw, qx, qy, qz;
    logic signed [qpr_pkg::POINT_W-1:0] px, py, pz;
  } rot_item_t;

  typedef struct {
    logic signed [qpr_pkg::POINT_W-1:0] rx, ry, rz;
    logic                               clip;
  } rot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, clipped;
  logic signed [qpr_pkg::QUAT_W-1:0] rot_w = '0, rot_x = '0, rot_y = '0, rot_z = '0;
  logic signed [qpr_pkg::POINT_W-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic signed [qpr_pkg::POINT_W-1:0] rotated_x, rotated_y, rotated_z;

  rot_item_t   pending_items[$];
  rot_result_t expected_rotations[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          hold_off = 0;
  int          checked_count = 0;
  bit          stimulus_done = 1'b0;
  int          send_wait = 0;
  int          recv_wait = 0;

  always #6 clk = ~clk;

  quaternion_point_rotate DUT (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .rot_w(rot_w), .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .empty(empty), .pop(pop),
    .rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
    .clipped(clipped)
  );

  function automatic longint div_round(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Exact sign(c) * floor(|c| * 2^UF / sqrt(m)) by squaring the ratio then taking a root.
  function automatic longint unit_component(input longint c, input longint m);
    longint a, quo, rem, res, t;
    a = (c < 0) ? -c : c;
    quo = (a * a) / m;
    rem = (a * a) - quo * m;
    for (int i = 0; i < 2 * UF; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= m) begin
        rem = rem - m;
        quo = quo | 1;
      end
    end
    res = 0;
    for (int b = 30; b >= 0; b--) begin
      t = res | (longint'(1) << b);
      if (t * t <= quo) res = t;
    end
    return (c < 0) ? -res : res;
  endfunction

  function automatic logic signed [qpr_pkg::POINT_W-1:0] saturate(input longint v,
                                                                  inout logic clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic rot_result_t rotate_point(input rot_item_t it);
    rot_result_t r;
    longint qw, qx, qy, qz, px, py, pz, m;
    longint uw, ux, uy, uz, tw, tx, ty, tz;
    logic clip;
    qw = it.qw; qx = it.qx; qy = it.qy; qz = it.qz;
    px = it.px; py = it.py; pz = it.pz;
    m = qw * qw + qx * qx + qy * qy + qz * qz;
    uw = 0; ux = 0; uy = 0; uz = 0;
    if (m != 0) begin
      uw = unit_component(qw, m);
      ux = unit_component(-qx, m);
      uy = unit_component(-qy, m);
      uz = unit_component(-qz, m);
    end
    tw = div_round(-(qx * px) - (qy * py) - (qz * pz), QF);
    tx = div_round((qw * px) + (qy * pz) - (qz * py), QF);
    ty = div_round((qw * py) + (qz * px) - (qx * pz), QF);
    tz = div_round((qw * pz) + (qx * py) - (qy * px), QF);
    clip = 1'b0;
    r.rx = saturate(div_round(tx * uw + tw * ux + ty * uz - tz * uy, UF), clip);
    r.ry = saturate(div_round(ty * uw + tw * uy + tz * ux - tx * uz, UF), clip);
    r.rz = saturate(div_round(tz * uw + tw * uz + tx * uy - ty * ux, UF), clip);
    r.clip = clip;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("Mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic it_drive(input rot_item_t it);
    rot_w <= it.qw; rot_x <= it.qx; rot_y <= it.qy; rot_z <= it.qz;
    point_x <= it.px; point_y <= it.py; point_z <= it.pz;
  endtask

  function automatic rot_item_t make_item(input int qw, input int qx, input int qy,
                                          input int qz, input int px, input int py,
                                          input int pz);
    rot_item_t it;
    it.qw = qw; it.qx = qx; it.qy = qy; it.qz = qz;
    it.px = px; it.py = py; it.pz = pz;
    return it;
  endfunction

  function automatic logic signed [qpr_pkg::QUAT_W-1:0] random_quat_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return '0;
      2: return 16'($signed($urandom_range(0, 32767)) - 16384) >>> 1;
      default: return qpr_pkg::QUAT_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [qpr_pkg::POINT_W-1:0] random_point_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1: return $signed($urandom_range(0, 65535 * 200)) - 32'sd6553600;
      2: return $signed(32'($urandom)) >>> $urandom_range(8, 24);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    rot_item_t it;
    // Directed: identity, zero quaternion, extremes of every field.
    pending_items.push_back(make_item(16384, 0, 0, 0, 65536, -131072, 196608));
    pending_items.push_back(make_item(0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 12345));
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(11585, 11585, 0, 0, 65536, 65536, 65536));
    pending_items.push_back(make_item(0, 0, 0, 16384, 65536, 0, 0));
    pending_items.push_back(make_item(32767, 32767, 32767, 32767,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_items.push_back(make_item(-32768, -32768, -32768, -32768,
                                      32'h80000000, 32'h80000000, 32'h80000000));
    pending_items.push_back(make_item(-32768, 32767, -32768, 32767,
                                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
    pending_items.push_back(make_item(32767, 0, 0, 0, 32'h7fffffff, 0, 0));
    pending_items.push_back(make_item(-32768, 0, 0, 0, 32'h80000000, 0, 0));
    pending_items.push_back(make_item(0, -32768, 0, 0, 0, 32'h7fffffff, 0));
    pending_items.push_back(make_item(0, 0, 32767, 0, 0, 0, 32'h80000000));
    pending_items.push_back(make_item(1, 0, 0, 0, 1, -1, 1));
    pending_items.push_back(make_item(0, 0, 0, -1, -1, -1, -1));
    pending_items.push_back(make_item(8192, -8192, 8192, -8192, 3276800, -655360, 1));
    pending_items.push_back(make_item(16384, 0, 0, 0, -1, 1, 32'h00008000));
    for (int n = 0; n < 1150; n++) begin
      it.qw = random_quat_comp(); it.qx = random_quat_comp();
      it.qy = random_quat_comp(); it.qz = random_quat_comp();
      it.px = random_point_comp(); it.py = random_point_comp();
      it.pz = random_point_comp();
      pending_items.push_back(it);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_items.size() == 0 && !push);
    stimulus_done = 1'b1;
  end

  // Driver: holds push high while an item is offered, draws a gap after each transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        expected_rotations.push_back(rotate_point(pending_items.pop_front()));
        send_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      end
      if (push && full) begin
        // keep offering the same item
      end else if (send_wait > 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it_drive(pending_items[0]);
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each popped transaction; one long hold-off fills the block.
  always @(posedge clk) begin
    rot_result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_rotations.size() == 0) begin
          report_mismatch("unexpected result", rotated_x, 0);
        end else begin
          want = expected_rotations.pop_front();
          if (rotated_x !== want.rx) report_mismatch("rotated_x", rotated_x, want.rx);
          if (rotated_y !== want.ry) report_mismatch("rotated_y", rotated_y, want.ry);
          if (rotated_z !== want.rz) report_mismatch("rotated_z", rotated_z, want.rz);
          if (clipped !== want.clip) report_mismatch("clipped", clipped, want.clip);
        end
        checked_count++;
        recv_wait = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        if (hold_off == 0 && checked_count == 200) hold_off = 300;
      end
      if (hold_off > 1) begin
        hold_off--;
        pop <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (stimulus_done && expected_rotations.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_rotations.size() == 0) begin
      $display("** quaternion_point_rotate: PASSED **");
    end else begin
      $display("** quaternion_point_rotate: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog expired with %0d results outstanding", expected_rotations.size());
    $display("** quaternion_point_rotate: FAILED **");
    $finish;
  end

endmodule
